// ----- src/bsr_pkg.sv -----
`timescale 1ns / 1ps

package bsr_pkg;

  localparam int RADIUS_W = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic s1_load;    // capture a vertex into the square stage
    logic acc_en;     // fold the square stage into the running maximum
    logic root_load;  // start a root on the final maximum, clear the maximum
    logic root_step;  // advance the root by one result bit
    logic out_load;   // move the finished root into the output register
  } bsr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic root_last;  // the current root step is the final one
  } bsr_status_t;

endpackage

// ----- src/bounding_sphere_radius.sv -----
`timescale 1ns / 1ps
// Result: a last vertex goes through the square stage, the root unit and the output
//   register; the root unit resolves one result bit per cycle.
// Throughput: one vertex per cycle inside a mesh; after a last vertex the input
//   stalls until the root finishes and the result enters the output register.
// Reset: asynchronous, active low; clears the running maximum and all valid state.

module bounding_sphere_radius import bsr_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [RADIUS_W-1:0]           radius_o
);

  // Command and status between the sequencer and the arithmetic
  bsr_cmd_t    cmd;
  bsr_status_t status;

  // Sequencer: hold the square stage valid bits, run the root, drive the
  // output register handshake
  bsr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_vertex_i (last_vertex_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // Datapath: squares, running maximum, bit-serial root, output register
  bsr_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .radius_o  (radius_o)
  );

endmodule

// ----- src/bsr_ctrl.sv -----
`timescale 1ns / 1ps

module bsr_ctrl import bsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        last_vertex_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bsr_cmd_t    cmd_o,
  input  bsr_status_t status_i
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_ROOT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   s1_valid_q, s1_valid_d;
  logic   s1_last_q, s1_last_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_RUN);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d           = state_q;
    cmd_o.s1_load     = accept;
    cmd_o.acc_en      = s1_valid_q;
    cmd_o.root_load   = s1_valid_q && s1_last_q;
    cmd_o.root_step   = 1'b0;
    cmd_o.out_load    = 1'b0;
    s1_valid_d        = accept;
    s1_last_d         = accept && last_vertex_i;
    unique case (state_q)
      ST_RUN: begin
        if (accept && last_vertex_i) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last vertex sits in the square stage; the root loads now
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      s1_last_q   <= s1_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_RUN);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/bsr_datapath.sv -----
`timescale 1ns / 1ps

module bsr_datapath import bsr_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  bsr_cmd_t                      cmd_i,
  output bsr_status_t                   status_o,
  output logic [RADIUS_W-1:0]           radius_o
);

  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int FULL_W = SQ_W + 2;
  localparam int SUM_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int EXT_W  = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;

  logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       max_q, max_d;
  logic                   sum_gt;
  logic [SUM_W-1:0]       rad_q, rad_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [ROOT_W-1:0]      root_q, root_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [REM_W-1:0]       rem_shift;
  logic [REM_W-1:0]       trial;
  logic [EXT_W-1:0]       root_ext;
  logic [RADIUS_W-1:0]    radius_q;

  assign mag_x = coord_x_i[COORD_WIDTH-1] ? (~coord_x_i + COORD_WIDTH'(1)) : coord_x_i;
  assign mag_y = coord_y_i[COORD_WIDTH-1] ? (~coord_y_i + COORD_WIDTH'(1)) : coord_y_i;
  assign mag_z = coord_z_i[COORD_WIDTH-1] ? (~coord_z_i + COORD_WIDTH'(1)) : coord_z_i;

  // Square stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.s1_load) begin
      sq_x_q <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y_q <= SQ_W'(mag_y) * SQ_W'(mag_y);
      sq_z_q <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  // Sum wraps at 64 bits for the widest coordinates
  assign sum    = SUM_W'(FULL_W'(sq_x_q) + FULL_W'(sq_y_q) + FULL_W'(sq_z_q));
  assign sum_gt = sum > max_q;

  always_comb begin
    max_d = max_q;
    if (cmd_i.root_load) begin
      max_d = '0;
    end else if (cmd_i.acc_en && sum_gt) begin
      max_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  // Restoring square root, one result bit per step
  assign rem_shift = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
  assign trial     = {root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (cmd_i.root_load) begin
      rad_d  = sum_gt ? sum : max_q;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.root_step) begin
      rad_d = {rad_q[SUM_W-3:0], 2'b00};
      cnt_d = cnt_q + CNT_W'(1);
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

  assign status_o.root_last = (cnt_q == CNT_W'(ROOT_W - 1));

  // Saturate roots that overflow the radius field
  assign root_ext = EXT_W'(root_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      radius_q <= (root_ext > EXT_W'({RADIUS_W{1'b1}})) ? {RADIUS_W{1'b1}}
                                                        : root_ext[RADIUS_W-1:0];
    end
  end

  assign radius_o = radius_q;

endmodule
